[rtl/core/utf8sd_pkg.sv]
// Shared types, constants and byte classification for the UTF-8 stream decoder.
// No dependencies; imported by utf8sd_decode and utf8_stream_decoder_top.
package utf8sd_pkg;

  localparam int unsigned CpWidth  = 21;
  localparam int unsigned CntWidth = 3;
  localparam int unsigned RepWidth = 3;

  localparam logic [CpWidth-1:0]  ReplacementCp = 21'h00FFFD;
  localparam logic [CntWidth-1:0] OneByte       = 3'd1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_req_t;

  typedef struct packed {
    logic [CpWidth-1:0]  code_point;
    logic [CntWidth-1:0] byte_count;
    logic                malformed;
    logic                run_last;
    logic                string_done;
  } out_res_t;

  // One decoded request: a number of replacement results, then optionally one
  // well-formed result (the tail), in that order.
  typedef struct packed {
    logic [RepWidth-1:0] rep_count;
    logic                tail_valid;
    logic [CpWidth-1:0]  tail_cp;
    logic [CntWidth-1:0] tail_cnt;
    logic                eos;
  } job_t;

  // Number of continuation bytes a lead byte calls for, zero when it is no lead.
  function automatic logic [1:0] lead_need(input logic [7:0] b);
    logic [1:0] need;
    begin
      need = 2'd0;
      if ((b & 8'hE0) == 8'hC0) begin
        need = 2'd1;
      end else if ((b & 8'hF0) == 8'hE0) begin
        need = 2'd2;
      end else if ((b & 8'hF8) == 8'hF0) begin
        need = 2'd3;
      end
      return need;
    end
  endfunction

endpackage

[rtl/core/utf8_stream_decoder_top.sv]
// Top level of the UTF-8 stream decoder: input register, job register and
// result register around utf8sd_decode. Depends on utf8sd_pkg.
//
// Usage: one byte of the string arrives per request on the in_ channel, with
// end_of_string set on the last byte. Decoded code points leave one per
// request on the out_ channel. Both channels use valid and stall; a request
// moves at a rising edge where valid is high and stall is low.
// Path: the input register takes the byte at the edge that accepts it; its
// results then pass through the job register and the result register, in
// that order, before they appear on out_valid.
// Throughput: one byte per cycle while each byte causes at most one result
// and out_stall is low. The job register hands out one result per cycle
// unless stalled, so a byte that causes several results (a broken or flushed
// sequence, up to four) holds back the next byte until its last result goes
// out. Bytes of a pending sequence cause no result and pass at full rate.
// Reset (rst_n low, synchronous) empties every stage and drops any pending
// sequence. When the receiver stalls, the result register holds its request
// steady; the job and input registers fill behind it and then in_stall rises.
module utf8_stream_decoder_top
  import utf8sd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_res_t out_res
);

  // Input register.
  logic    in_v_r;
  in_req_t in_d_r;

  // Job register: replacements still to send, then the optional tail.
  logic [RepWidth-1:0] j_rep_r;
  logic                j_tail_r;
  logic [CpWidth-1:0]  j_cp_r;
  logic [CntWidth-1:0] j_cnt_r;
  logic                j_eos_r;

  // Result register.
  logic     out_v_r;
  out_res_t out_r, out_nxt;

  job_t job;
  logic o_load, pop, j_empty, j_one, j_free, adv;

  assign j_empty = (j_rep_r == '0) && !j_tail_r;
  assign j_one   = ((j_rep_r == 3'd1) && !j_tail_r) || ((j_rep_r == '0) && j_tail_r);
  assign o_load  = !out_v_r || !out_stall;
  assign pop     = o_load && !j_empty;
  // The job register takes the next byte once its last result goes out.
  assign j_free  = j_empty || (j_one && pop);
  assign adv     = in_v_r && j_free;
  assign in_stall = in_v_r && !j_free;

  utf8sd_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (in_d_r),
    .adv   (adv),
    .job   (job)
  );

  // The next result: replacements first, the tail last.
  always_comb begin
    if (j_rep_r != '0) begin
      out_nxt.code_point = ReplacementCp;
      out_nxt.byte_count = OneByte;
      out_nxt.malformed  = 1'b1;
    end else begin
      out_nxt.code_point = j_cp_r;
      out_nxt.byte_count = j_cnt_r;
      out_nxt.malformed  = 1'b0;
    end
    out_nxt.run_last    = j_one;
    out_nxt.string_done = j_one && j_eos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      j_rep_r  <= '0;
      j_tail_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (!in_v_r || adv) begin
        in_v_r <= in_valid;
      end
      if (adv) begin
        j_rep_r  <= job.rep_count;
        j_tail_r <= job.tail_valid;
      end else if (pop) begin
        if (j_rep_r != '0) begin
          j_rep_r <= j_rep_r - 3'd1;
        end else begin
          j_tail_r <= 1'b0;
        end
      end
      if (o_load) begin
        out_v_r <= pop;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (!in_v_r || adv) begin
      in_d_r <= in_req;
    end
    if (adv) begin
      j_cp_r  <= job.tail_cp;
      j_cnt_r <= job.tail_cnt;
      j_eos_r <= job.eos;
    end
    if (pop) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_r;

  // A replacement always stands for exactly one source byte.
  a_malformed_one_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.malformed |-> (out_r.code_point == ReplacementCp) &&
                                   (out_r.byte_count == OneByte))
    else $error("malformed result without a single-byte replacement");

  // The end of a string is always the last result of its byte.
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.string_done |-> out_r.run_last)
    else $error("string_done on a result that is not run_last");

  // No byte causes more than four replacements.
  a_rep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    j_rep_r <= 3'd4)
    else $error("replacement count above four");

  // Two-byte sequences decode below 0x800.
  a_two_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_r.malformed && (out_r.byte_count == 3'd2) |->
      (out_r.code_point < 21'h000800))
    else $error("two-byte code point out of range");

  // A byte only enters the job register once the previous job has drained.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    adv |-> j_empty || (j_one && pop))
    else $error("job register overwritten with results pending");

endmodule

[rtl/core/utf8sd_decode.sv]
// Sequence state and single-pass decode of one byte into a result job.
// Depends on utf8sd_pkg.
module utf8sd_decode
  import utf8sd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  in_req_t req,
  input  logic    adv,
  output job_t    job
);

  logic [7:0] lead_r, lead_nxt;
  logic [7:0] cont0_r, cont0_nxt;
  logic [7:0] cont1_r, cont1_nxt;
  logic [1:0] hc_r, hc_nxt;

  logic [7:0]          b;
  logic                is_cont;
  logic [1:0]          need;
  logic                fresh;
  logic [RepWidth-1:0] rep;
  logic                tail_v;
  logic [CpWidth-1:0]  tail_cp;
  logic [CntWidth-1:0] tail_cnt;

  assign b       = req.in_byte;
  assign is_cont = (b[7:6] == 2'b10);

  always_comb begin
    need = (lead_need(lead_r) == 2'd0) ? 2'd1 : lead_need(lead_r);
  end

  always_comb begin
    rep       = '0;
    tail_v    = 1'b0;
    tail_cp   = '0;
    tail_cnt  = OneByte;
    hc_nxt    = hc_r;
    lead_nxt  = lead_r;
    cont0_nxt = cont0_r;
    cont1_nxt = cont1_r;
    fresh     = 1'b1;
    if (hc_r != 2'd0) begin
      if (is_cont) begin
        fresh = 1'b0;
        if (hc_r >= need) begin
          tail_v   = 1'b1;
          tail_cnt = {1'b0, need} + OneByte;
          hc_nxt   = 2'd0;
          unique case (need)
            2'd1:    tail_cp = {10'd0, lead_r[4:0], b[5:0]};
            2'd2:    tail_cp = {5'd0, lead_r[3:0], cont0_r[5:0], b[5:0]};
            default: tail_cp = {lead_r[2:0], cont0_r[5:0], cont1_r[5:0], b[5:0]};
          endcase
        end else begin
          if (hc_r == 2'd1) begin
            cont0_nxt = b;
          end else begin
            cont1_nxt = b;
          end
          hc_nxt = hc_r + 2'd1;
        end
      end else begin
        // Broken sequence: every held byte becomes a replacement.
        rep    = {1'b0, hc_r};
        hc_nxt = 2'd0;
      end
    end
    if (fresh) begin
      if (!b[7]) begin
        tail_v  = 1'b1;
        tail_cp = {13'd0, b};
      end else if (lead_need(b) != 2'd0) begin
        lead_nxt = b;
        hc_nxt   = 2'd1;
      end else begin
        rep = rep + 3'd1;
      end
    end
    if (req.end_of_string && (hc_nxt != 2'd0)) begin
      rep    = rep + {1'b0, hc_nxt};
      hc_nxt = 2'd0;
    end
  end

  assign job.rep_count  = rep;
  assign job.tail_valid = tail_v;
  assign job.tail_cp    = tail_cp;
  assign job.tail_cnt   = tail_cnt;
  assign job.eos        = req.end_of_string;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r    <= 2'd0;
      lead_r  <= 8'd0;
      cont0_r <= 8'd0;
      cont1_r <= 8'd0;
    end else if (adv) begin
      hc_r    <= hc_nxt;
      lead_r  <= lead_nxt;
      cont0_r <= cont0_nxt;
      cont1_r <= cont1_nxt;
    end
  end

endmodule
